### hw/rtl/atilt_pkg.sv
// Shared widths, arctangent step table and flag types for the tilt angle unit.
`default_nettype none

package atilt_pkg;

  localparam int AXIS_W    = 16;  // raw axis sample
  localparam int ANGLE_W   = 16;  // result angle
  localparam int SQ_W      = 31;  // square of one axis, at most 2^30
  localparam int SUM_W     = 32;  // sum of two squares
  localparam int ROOT_W    = 24;  // magnitude with 8 fraction bits
  localparam int REM_W     = 28;  // square root partial remainder
  localparam int Q8_W      = 25;  // signed numerator or divisor, 8 fraction bits
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN = 24;
  localparam int ANGLE_MAX = 32767;

  localparam int DEF_ROTATION_STEPS      = 16;
  localparam int DEF_ANGLE_FRACTION_BITS = 8;

  // atan(2^-i) in degrees times 2^24
  localparam longint ATAN_Q24 [TABLE_LEN] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  // Sign and special-case flags that ride along with one rotation
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic num_neg;
    logic neg;
  } aflags_t;

  // Rotation angle of step idx, rounded to frac_bits plus guard bits
  function automatic longint atan_step(input int idx, input int frac_bits);
    int sh;
    sh = 24 - frac_bits - GUARD_BITS;
    return (ATAN_Q24[idx] + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/atilt_if.sv
// Valid/ready channel interfaces for samples in and angles out.
`default_nettype none

interface atilt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [atilt_pkg::AXIS_W-1:0] accel_x;
  logic signed [atilt_pkg::AXIS_W-1:0] accel_y;
  logic signed [atilt_pkg::AXIS_W-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atilt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [atilt_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [atilt_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [atilt_pkg::ANGLE_W-1:0] tilt_from_vertical;

  modport source (output valid, pitch_angle, roll_angle, tilt_from_vertical, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, tilt_from_vertical, output ready);
endinterface

`default_nettype wire

### hw/rtl/atilt_mag3.sv
// Pipelined squares, pair sums and bit-per-stage square roots of the three magnitudes.
`default_nettype none

module atilt_mag3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                ce,
  input  logic                                in_valid,
  input  logic signed [atilt_pkg::AXIS_W-1:0] in_x,
  input  logic signed [atilt_pkg::AXIS_W-1:0] in_y,
  input  logic signed [atilt_pkg::AXIS_W-1:0] in_z,
  output logic                                out_valid,
  output logic signed [atilt_pkg::AXIS_W-1:0] out_x,
  output logic signed [atilt_pkg::AXIS_W-1:0] out_y,
  output logic signed [atilt_pkg::AXIS_W-1:0] out_z,
  output logic        [atilt_pkg::ROOT_W-1:0] out_mag_yz,
  output logic        [atilt_pkg::ROOT_W-1:0] out_mag_xz,
  output logic        [atilt_pkg::ROOT_W-1:0] out_mag_xy
);
  import atilt_pkg::*;

  logic signed [2*AXIS_W-1:0] px, py, pz;
  logic                       vq_r;
  logic signed [AXIS_W-1:0]   xq_r, yq_r, zq_r;
  logic [SQ_W-1:0]            xx_r, yy_r, zz_r;

  logic                       v_r  [0:ROOT_W];
  logic signed [AXIS_W-1:0]   xa_r [0:ROOT_W];
  logic signed [AXIS_W-1:0]   ya_r [0:ROOT_W];
  logic signed [AXIS_W-1:0]   za_r [0:ROOT_W];
  logic [SUM_W-1:0]           s_r   [0:2][0:ROOT_W];
  logic [REM_W-1:0]           rem_r [0:2][0:ROOT_W];
  logic [ROOT_W-1:0]          rt_r  [0:2][0:ROOT_W];

  assign px = in_x * in_x;
  assign py = in_y * in_y;
  assign pz = in_z * in_z;

  // Square each axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (ce) begin
      vq_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xq_r <= in_x;
      yq_r <= in_y;
      zq_r <= in_z;
      xx_r <= px[SQ_W-1:0];
      yy_r <= py[SQ_W-1:0];
      zz_r <= pz[SQ_W-1:0];
    end
  end

  // Form the three pair sums and seed the root stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xa_r[0] <= xq_r;
      ya_r[0] <= yq_r;
      za_r[0] <= zq_r;
      s_r[0][0] <= SUM_W'(yy_r) + SUM_W'(zz_r);
      s_r[1][0] <= SUM_W'(xx_r) + SUM_W'(zz_r);
      s_r[2][0] <= SUM_W'(xx_r) + SUM_W'(yy_r);
      for (int c = 0; c < 3; c++) begin
        rem_r[c][0] <= '0;
        rt_r[c][0]  <= '0;
      end
    end
  end

  // One root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (ce) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        xa_r[j+1] <= xa_r[j];
        ya_r[j+1] <= ya_r[j];
        za_r[j+1] <= za_r[j];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [2*ROOT_W-1:0] nn;
      logic [REM_W-1:0]    rs;
      logic [REM_W-1:0]    tr;

      // radicand is the sum scaled by 2^16
      assign nn = {s_r[c][j], {(2*ROOT_W-SUM_W){1'b0}}};
      assign rs = {rem_r[c][j][REM_W-3:0], nn[2*ROOT_W-1-2*j -: 2]};
      assign tr = REM_W'({rt_r[c][j], 2'b01});

      always_ff @(posedge clk) begin
        if (ce) begin
          s_r[c][j+1] <= s_r[c][j];
          if (rs >= tr) begin
            rem_r[c][j+1] <= rs - tr;
            rt_r[c][j+1]  <= {rt_r[c][j][ROOT_W-2:0], 1'b1};
          end else begin
            rem_r[c][j+1] <= rs;
            rt_r[c][j+1]  <= {rt_r[c][j][ROOT_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid  = v_r[ROOT_W];
  assign out_x      = xa_r[ROOT_W];
  assign out_y      = ya_r[ROOT_W];
  assign out_z      = za_r[ROOT_W];
  assign out_mag_yz = rt_r[0][ROOT_W];
  assign out_mag_xz = rt_r[1][ROOT_W];
  assign out_mag_xy = rt_r[2][ROOT_W];

endmodule

`default_nettype wire

### hw/rtl/atilt_cordic.sv
// Pipelined vectoring rotation: arctangent of a signed ratio in degrees.
`default_nettype none

module atilt_cordic #(
  parameter int ROTATION_STEPS      = atilt_pkg::DEF_ROTATION_STEPS,
  parameter int ANGLE_FRACTION_BITS = atilt_pkg::DEF_ANGLE_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 ce,
  input  logic                                 in_valid,
  input  logic signed [atilt_pkg::Q8_W-1:0]    in_num,
  input  logic signed [atilt_pkg::Q8_W-1:0]    in_den,
  output logic                                 out_valid,
  output logic signed [atilt_pkg::ANGLE_W-1:0] out_angle
);
  import atilt_pkg::*;

  localparam int N     = ROTATION_STEPS;
  localparam int CW    = Q8_W + 3;
  localparam int ACC_W = ANGLE_FRACTION_BITS + GUARD_BITS + 8;
  localparam int RND_W = ACC_W - GUARD_BITS;
  localparam longint ACC_MAX_L = longint'(90) << (ANGLE_FRACTION_BITS + GUARD_BITS);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(ACC_MAX_L);
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(longint'(1) << (GUARD_BITS - 1));
  localparam longint FULL_L = longint'(90) << ANGLE_FRACTION_BITS;
  localparam logic [ANGLE_W-1:0] FULL_SAT =
    (FULL_L > longint'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(FULL_L);

  logic signed [CW-1:0]    num_e, den_e;
  logic                    v_r   [0:N];
  logic signed [CW-1:0]    x_r   [0:N];
  logic signed [CW-1:0]    y_r   [0:N];
  logic signed [ACC_W-1:0] acc_r [0:N];
  aflags_t                 fl_r  [0:N];
  aflags_t                 fl_in;

  logic signed [ACC_W-1:0] acc_cl, acc_rs;
  logic                    v1_r, v2_r;
  aflags_t                 fl1_r;
  logic [RND_W-1:0]        rnd_r;
  logic [31:0]             rnd_w;
  logic [ANGLE_W-1:0]      mag;
  logic signed [ANGLE_W-1:0] ang_nxt, ang_r;

  assign num_e = {{(CW-Q8_W){in_num[Q8_W-1]}}, in_num};
  assign den_e = {{(CW-Q8_W){in_den[Q8_W-1]}}, in_den};

  always_comb begin
    fl_in.den_zero = (in_den == '0);
    fl_in.num_zero = (in_num == '0);
    fl_in.num_neg  = in_num[Q8_W-1];
    fl_in.neg      = in_num[Q8_W-1] ^ in_den[Q8_W-1];
  end

  // Fold into the first quadrant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r[0]   <= den_e[CW-1] ? -den_e : den_e;
      y_r[0]   <= num_e[CW-1] ? -num_e : num_e;
      acc_r[0] <= '0;
      fl_r[0]  <= fl_in;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ACC_W-1:0] STEP = ACC_W'(atan_step(i, ANGLE_FRACTION_BITS));
    logic signed [CW-1:0] dx, dy;

    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ce) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        fl_r[i+1] <= fl_r[i];
        if (!y_r[i][CW-1]) begin
          x_r[i+1]   <= x_r[i] + dy;
          y_r[i+1]   <= y_r[i] - dx;
          acc_r[i+1] <= acc_r[i] + STEP;
        end else begin
          x_r[i+1]   <= x_r[i] - dy;
          y_r[i+1]   <= y_r[i] + dx;
          acc_r[i+1] <= acc_r[i] - STEP;
        end
      end
    end
  end

  // Clamp to 0..90 degrees and round off the guard bits
  always_comb begin
    if (acc_r[N][ACC_W-1]) begin
      acc_cl = '0;
    end else if (acc_r[N] > ACC_MAX) begin
      acc_cl = ACC_MAX;
    end else begin
      acc_cl = acc_r[N];
    end
    acc_rs = acc_cl + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v_r[N];
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rnd_r <= acc_rs[ACC_W-1:GUARD_BITS];
      fl1_r <= fl_r[N];
      ang_r <= ang_nxt;
    end
  end

  // Saturate, apply sign and the zero cases
  always_comb begin
    rnd_w = 32'(rnd_r);
    mag   = (rnd_w > 32'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : rnd_w[ANGLE_W-1:0];
    if (fl1_r.den_zero) begin
      if (fl1_r.num_zero) begin
        ang_nxt = '0;
      end else begin
        ang_nxt = fl1_r.num_neg ? -$signed(FULL_SAT) : $signed(FULL_SAT);
      end
    end else if (fl1_r.num_zero) begin
      ang_nxt = '0;
    end else begin
      ang_nxt = fl1_r.neg ? -$signed(mag) : $signed(mag);
    end
  end

  assign out_valid = v2_r;
  assign out_angle = ang_r;

endmodule

`default_nettype wire

### hw/rtl/accel_tilt_angles_unit.sv
// Top level: pitch, roll and tilt angles from one three-axis accelerometer sample.
`default_nettype none

// Takes one signed 16-bit x/y/z sample per beat and returns pitch, roll and tilt from
// vertical in degrees with ANGLE_FRACTION_BITS fraction bits, each within +/-90. A new
// sample can enter every cycle unless a result waits unread; each passes the square and
// pair-sum registers, the bit-per-stage square roots, the rotation pipeline and then the
// output register. When a result is held back by out_if.ready the whole pipeline
// freezes, so in_if.ready drops only while the output register is full and not being
// taken. A zero divisor gives +/-90 degrees, or 0 with a zero numerator.
module accel_tilt_angles_unit #(
  parameter int ROTATION_STEPS      = atilt_pkg::DEF_ROTATION_STEPS,
  parameter int ANGLE_FRACTION_BITS = atilt_pkg::DEF_ANGLE_FRACTION_BITS
) (
  input logic        clk,
  input logic        rst_n,
  atilt_in_if.sink   in_if,
  atilt_out_if.source out_if
);
  import atilt_pkg::*;

  logic                     ce;
  logic                     m_valid;
  logic signed [AXIS_W-1:0] m_x, m_y, m_z;
  logic [ROOT_W-1:0]        m_yz, m_xz, m_xy;
  logic signed [Q8_W-1:0]   num_p, den_p, num_r, den_r, num_t, den_t;
  logic                     vp, vr, vt;
  logic signed [ANGLE_W-1:0] ang_p, ang_r, ang_t;

  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] pitch_r, roll_r, tilt_r;

  // Advance everything unless a result waits unread
  assign ce          = !out_valid_r || out_if.ready;
  assign in_if.ready = ce;

  atilt_mag3 u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (in_if.valid),
    .in_x       (in_if.accel_x),
    .in_y       (in_if.accel_y),
    .in_z       (in_if.accel_z),
    .out_valid  (m_valid),
    .out_x      (m_x),
    .out_y      (m_y),
    .out_z      (m_z),
    .out_mag_yz (m_yz),
    .out_mag_xz (m_xz),
    .out_mag_xy (m_xy)
  );

  // Axis values scaled by 256 and sign extended, magnitudes already carry 8 fraction bits
  assign num_p = {m_x[AXIS_W-1], m_x, 8'b0};
  assign den_p = Q8_W'({1'b0, m_yz});
  assign num_r = {m_y[AXIS_W-1], m_y, 8'b0};
  assign den_r = Q8_W'({1'b0, m_xz});
  assign num_t = Q8_W'({1'b0, m_xy});
  assign den_t = {m_z[AXIS_W-1], m_z, 8'b0};

  atilt_cordic #(
    .ROTATION_STEPS      (ROTATION_STEPS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_pitch (
    .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (m_valid),
    .in_num (num_p), .in_den (den_p), .out_valid (vp), .out_angle (ang_p)
  );

  atilt_cordic #(
    .ROTATION_STEPS      (ROTATION_STEPS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_roll (
    .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (m_valid),
    .in_num (num_r), .in_den (den_r), .out_valid (vr), .out_angle (ang_r)
  );

  atilt_cordic #(
    .ROTATION_STEPS      (ROTATION_STEPS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_tilt (
    .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (m_valid),
    .in_num (num_t), .in_den (den_t), .out_valid (vt), .out_angle (ang_t)
  );

  // Output register holds the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pitch_r <= ang_p;
      roll_r  <= ang_r;
      tilt_r  <= ang_t;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.pitch_angle        = pitch_r;
  assign out_if.roll_angle         = roll_r;
  assign out_if.tilt_from_vertical = tilt_r;

  // The three rotation pipelines stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (vp == vr) && (vr == vt))
    else $error("rotation lanes out of step");

  // Delivered pitch lies within +/-ANGLE_MAX; pitch and tilt from the rotation lanes stay at or above -ANGLE_MAX
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((pitch_r <= $signed({1'b0, ANGLE_W'(ANGLE_MAX)})) &&
                     (pitch_r >= -$signed({1'b0, ANGLE_W'(ANGLE_MAX)}))) &&
                    (ang_p >= -$signed({1'b0, ANGLE_W'(ANGLE_MAX)})) &&
                    (ang_t >= -$signed({1'b0, ANGLE_W'(ANGLE_MAX)})))
    else $error("angle out of range");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid survived reset");

endmodule

`default_nettype wire

### tb/tb_tilt_scoreboard.sv
// Scoreboard class: predicts pitch, roll and tilt angles and checks each output beat.
`timescale 1ns / 100ps

class tilt_scoreboard;
  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] tilt;
  } angles_t;

  angles_t pending_angles[$];
  int      mismatches;
  int      unexpected;
  int      checked;

  function new();
    mismatches = 0;
    unexpected = 0;
    checked    = 0;
  endfunction

  // exact integer square root
  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function longint magnitude_q8(longint a, longint b);
    longint unsigned s;
    s = longint'(a * a) + longint'(b * b);
    return longint'(int_sqrt(s << 16));
  endfunction

  // shift right rounding toward minus infinity
  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // atan(num / den) in degrees * 256, both operands with 8 fraction bits
  static function longint atan_degrees(longint num, longint den);
    longint full;
    longint x;
    longint y;
    longint acc;
    longint mag;
    longint step;
    longint dx;
    longint dy;
    bit     neg;
    full = 90 * 256;
    if (den == 0) begin
      if (num == 0) return 0;
      return (num < 0) ? -full : full;
    end
    if (num == 0) return 0;
    neg = (num < 0) != (den < 0);
    x   = (den < 0) ? -den : den;
    y   = (num < 0) ? -num : num;
    acc = 0;
    for (int i = 0; i < 16; i++) begin
      step = (atilt_pkg::ATAN_Q24[i] + (longint'(1) << 7)) >>> 8;
      dx   = floor_shift(x, i);
      dy   = floor_shift(y, i);
      if (y >= 0) begin
        x = x + dy; y = y - dx; acc = acc + step;
      end else begin
        x = x - dy; y = y + dx; acc = acc - step;
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(90) << 16)) acc = longint'(90) << 16;
    mag = (acc + 128) >>> 8;
    if (mag > 32767) mag = 32767;
    return neg ? -mag : mag;
  endfunction

  // note an accepted sample
  function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az);
    angles_t e;
    longint  x;
    longint  y;
    longint  z;
    x = ax; y = ay; z = az;
    e.pitch = 16'(atan_degrees(x * 256, magnitude_q8(y, z)));
    e.roll  = 16'(atan_degrees(y * 256, magnitude_q8(x, z)));
    e.tilt  = 16'(atan_degrees(magnitude_q8(x, y), z * 256));
    pending_angles.push_back(e);
  endfunction

  // compare one output beat against the oldest prediction
  function void check_angles(logic signed [15:0] p, logic signed [15:0] r,
                             logic signed [15:0] t);
    angles_t e;
    if (pending_angles.size() == 0) begin
      $error("unexpected output beat: pitch %0d roll %0d tilt %0d", p, r, t);
      unexpected++;
      return;
    end
    e = pending_angles.pop_front();
    checked++;
    if (p !== e.pitch) begin
      $error("pitch_angle: expected %0d, got %0d", e.pitch, p);
      mismatches++;
    end
    if (r !== e.roll) begin
      $error("roll_angle: expected %0d, got %0d", e.roll, r);
      mismatches++;
    end
    if (t !== e.tilt) begin
      $error("tilt_from_vertical: expected %0d, got %0d", e.tilt, t);
      mismatches++;
    end
  endfunction
endclass

### tb/tb.sv
// Testbench top: drives samples into the tilt angle unit and checks every angle beat.
`timescale 1ns / 100ps

module tb;
  localparam int LATENCY = 16 + 30;
  localparam int RANDOM_SAMPLES = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   stall_en = 1'b0;
  int   stall_mode = 0;
  int   stall_phase = 0;

  atilt_in_if  in_if ();
  atilt_out_if out_if ();

  accel_tilt_angles_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  tilt_scoreboard angle_board = new();

  always #5 clk = ~clk;

  initial begin
    in_if.valid   = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    out_if.ready  = 1'b0;
  end

  // record accepted samples, check accepted angle beats
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      angle_board.note_sample(in_if.accel_x, in_if.accel_y, in_if.accel_z);
    if (rst_n && out_if.valid && out_if.ready)
      angle_board.check_angles(out_if.pitch_angle, out_if.roll_angle,
                               out_if.tilt_from_vertical);
  end

  // receiver stall pattern: periodic, random or none, switching now and then
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    if (!stall_en)
      out_if.ready <= 1'b1;
    else case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= (stall_phase % 7) < 4;
      default: out_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // present one sample and hold it until accepted
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    in_if.valid   <= 1'b1;
    in_if.accel_x <= ax;
    in_if.accel_y <= ay;
    in_if.accel_z <= az;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic idle_gap(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'($urandom_range(0, 15)) - 16'sd8;
      4: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [15:0] corner[5];
    int burst;
    corner = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero, lone axes, extremes, negative z
    send_sample(0, 0, 0);
    send_sample(16'sh7fff, 0, 0);
    send_sample(16'sh8000, 0, 0);
    send_sample(0, 16'sh8000, 0);
    send_sample(0, 0, 16'sh7fff);
    send_sample(0, 0, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000, -16'sd1);
    send_sample(1, -1, -16'sd2);
    send_sample(-16'sd1, 1, 1);
    for (int i = 0; i < 12; i++)
      send_sample(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
                  corner[$urandom_range(0, 4)]);
    send_sample(16'h5555, 16'haaaa, 16'h5555);
    send_sample(16'haaaa, 16'h5555, 16'haaaa);
    stall_en <= 1'b1;

    // random samples in bursts with gaps
    for (int n = 0; n < RANDOM_SAMPLES; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++)
        send_sample(pick_axis(), pick_axis(), pick_axis());
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_if.valid <= 1'b0;

    while (angle_board.pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("tb: %0d samples checked, covering axis extremes, zero divisors and stalls",
             angle_board.checked);
    if (angle_board.mismatches == 0 && angle_board.unexpected == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
